// File: rtl/pfa_pkg.sv
// Shared types, constants and helper functions of the pair force accumulator.
`timescale 1ns / 1ps
package pfa_pkg;

    localparam int NUM_PARTICLES = 1024;
    localparam int INDEX_W       = 10;
    localparam int POS_W         = 32;
    localparam int FRC_W         = 48;
    localparam int CFG_W         = 31;
    localparam int CFG_DATA_W    = 32;
    localparam int POS_WORD_W    = 3 * POS_W;
    localparam int FRC_WORD_W    = 3 * FRC_W;
    localparam int DIST_W        = 35;
    localparam int DMAG_W        = 24;
    localparam int SUM_W         = 50;
    localparam int RD_W          = 34;
    localparam int RR_W          = 49;
    localparam int SMAG_W        = 63;
    localparam int DIV_STEPS     = 49;
    localparam int DIV_CNT_W     = 6;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_PAIR = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_ZERO = 2'd1;
    localparam logic [1:0] FAULT_SAT  = 2'd2;

    localparam logic CFG_HALF_BOX  = 1'b0;
    localparam logic CFG_CUTOFF_SQ = 1'b1;

    localparam logic [CFG_W-1:0] CUTOFF_SQ_RST = 31'd589824;

    localparam logic [63:0] CAP_SQ  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] CAP_Q32 = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] CAP_FRC = 64'h0000_7FFF_FFFF_FFFF;

    localparam logic signed [FRC_W:0] SUM_MAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [FRC_W:0] SUM_MIN = -49'sh0_8000_0000_0000;

    typedef struct packed {
        logic [1:0]               kind;
        logic [INDEX_W-1:0]       first_index;
        logic [INDEX_W-1:0]       second_index;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
    } t_in;

    typedef struct packed {
        logic signed [FRC_W-1:0]  force_x;
        logic signed [FRC_W-1:0]  force_y;
        logic signed [FRC_W-1:0]  force_z;
        logic                     within_cutoff;
        logic [1:0]               fault;
    } t_out;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POS_A,
        ST_POS_B,
        ST_WRAP,
        ST_SQ,
        ST_SQ_WAIT,
        ST_CMP,
        ST_DIV_WAIT,
        ST_PWR,
        ST_PWR_WAIT,
        ST_FRC,
        ST_FRC_WAIT,
        ST_ACC_A_RD,
        ST_ACC_A_WR,
        ST_ACC_B_RD,
        ST_ACC_B_WR,
        ST_RD_F,
        ST_RD_W,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MM_SQ,
        MM_Q32,
        MM_FRC
    } t_mul_mode;

    typedef struct packed {
        logic      start;
        t_mul_mode mode;
    } t_mul_req;

    typedef struct packed {
        logic done;
        logic sat;
    } t_mul_rsp;

    // Minimum-image difference of one axis.
    function automatic logic signed [DIST_W-1:0] wrap_axis(
        input logic signed [POS_W-1:0] pa,
        input logic signed [POS_W-1:0] pb,
        input logic [CFG_W-1:0]        h
    );
        logic signed [DIST_W-1:0] v;
        logic signed [DIST_W-1:0] hs;
        begin
            hs = $signed({4'b0000, h});
            v  = DIST_W'(pa) - DIST_W'(pb);
            if (v < -hs) begin
                v = v + hs + hs;
            end
            if (v > hs) begin
                v = v - hs - hs;
            end
            return v;
        end
    endfunction

    // Saturating 48-bit add; the top bit of the result flags saturation.
    function automatic logic [FRC_W:0] sat_add(
        input logic signed [FRC_W-1:0] a,
        input logic signed [FRC_W-1:0] b
    );
        logic signed [FRC_W:0] s;
        begin
            s = (FRC_W+1)'(a) + (FRC_W+1)'(b);
            if (s > SUM_MAX) begin
                return {1'b1, SUM_MAX[FRC_W-1:0]};
            end else if (s < SUM_MIN) begin
                return {1'b1, SUM_MIN[FRC_W-1:0]};
            end
            return {1'b0, s[FRC_W-1:0]};
        end
    endfunction

endpackage

// File: rtl/pair_force_accumulator_core.sv
// Top level: sequencer, position and force stores, and the shared arithmetic units.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+----------------------------
//  in      | into      | i_in_valid / o_in_ready    | i_in_data  (pfa_pkg::t_in)
//  out     | out of    | o_out_valid / i_out_ready  | o_out_data (pfa_pkg::t_out)
//  cfg     | into      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A load, a read or a pair request holds the block until its result is registered: a pair
// forms the reciprocal in 49 restoring-division steps and a handover, and makes ten
// multiplies on the one 32 x 32 multiplier.
// After reset the force store is cleared one entry a cycle over all NUM_PARTICLES entries
// (1024), during which no request is taken; configuration writes are always taken.
// A finished result sits in the output register, so the next request is taken while
// the previous result waits on i_out_ready; the next result then stalls until it leaves.
module pair_force_accumulator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pfa_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pfa_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pfa_pkg::*;

    // Stores: each word holds x, y, z from the top bits down.
    logic [POS_WORD_W-1:0] r_pos_mem [NUM_PARTICLES];
    logic [FRC_WORD_W-1:0] r_frc_mem [NUM_PARTICLES];
    logic [POS_WORD_W-1:0] r_pos_q;
    logic [FRC_WORD_W-1:0] r_frc_q;

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0]   r_half_box;
    logic [CFG_W-1:0]   r_cutoff_sq;
    logic [INDEX_W-1:0] r_clr_cnt;

    t_in                     r_item;
    logic [POS_WORD_W-1:0]   r_pa;
    logic [DMAG_W-1:0]       r_dmag [3];
    logic                    r_dneg [3];
    logic [SUM_W-1:0]        r_sum;
    logic [RR_W-1:0]         r_rr;
    logic [63:0]             r_r2;
    logic [63:0]             r_r4;
    logic [63:0]             r_r6;
    logic [SMAG_W-1:0]       r_smag;
    logic                    r_sneg;
    logic signed [FRC_W-1:0] r_f [3];
    logic                    r_sat;
    logic [1:0]              r_lane;
    logic [1:0]              r_step;
    t_out                    r_res;
    t_out                    r_out;
    logic                    r_ovalid;

    logic                    w_in_acc;
    logic                    w_a_ok;
    logic                    w_b_ok;
    logic                    w_new_a_ok;
    logic                    w_new_b_ok;
    logic [INDEX_W-1:0]      w_pos_raddr;
    logic [INDEX_W-1:0]      w_frc_raddr;
    logic                    w_frc_we;
    logic [INDEX_W-1:0]      w_frc_waddr;
    logic [FRC_WORD_W-1:0]   w_frc_wdata;
    logic                    w_acc_sat;
    logic signed [DIST_W-1:0] w_d [3];
    logic                    w_far;
    logic [RD_W-1:0]         w_rd;
    logic                    w_in_cut;
    logic                    w_rd_zero;
    logic                    w_out_free;

    t_mul_req                w_mul_req;
    t_mul_rsp                w_mul_rsp;
    logic [63:0]             w_mul_a;
    logic [63:0]             w_mul_b;
    logic [63:0]             w_mul_res;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [RR_W-1:0]         w_div_quot;

    logic signed [64:0]      w_s;
    logic [64:0]             w_s_abs;
    logic [FRC_W-1:0]        w_m;

    pfa_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_mul_req),
        .i_a      (w_mul_a),
        .i_b      (w_mul_b),
        .o_rsp    (w_mul_rsp),
        .o_result (w_mul_res)
    );

    pfa_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_divisor (w_rd[CFG_W-1:0]),
        .o_done    (w_div_done),
        .o_quot    (w_div_quot)
    );

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_ovalid || i_out_ready;

    // Index range checks on the held request and on the incoming one.
    assign w_a_ok     = (32'(r_item.first_index) < NUM_PARTICLES);
    assign w_b_ok     = (32'(r_item.second_index) < NUM_PARTICLES);
    assign w_new_a_ok = (32'(i_in_data.first_index) < NUM_PARTICLES);
    assign w_new_b_ok = (32'(i_in_data.second_index) < NUM_PARTICLES);

    // Per-axis minimum-image separation; the second position is on the read port.
    always_comb begin
        w_far = 1'b0;
        for (int k = 0; k < 3; k++) begin
            w_d[k] = wrap_axis(r_pa[(2-k)*POS_W +: POS_W], r_pos_q[(2-k)*POS_W +: POS_W],
                               r_half_box);
            if ((w_d[k] >= 35'sd16777216) || (w_d[k] <= -35'sd16777216)) begin
                w_far = 1'b1;
            end
        end
    end

    // Squared distance in Q16.16 and its cutoff tests.
    assign w_rd      = r_sum[SUM_W-1:16];
    assign w_in_cut  = (w_rd < {3'b000, r_cutoff_sq});
    assign w_rd_zero = (w_rd == '0);

    // Bracket term r^-14 - r^-8 / 2, formed as the last power product lands.
    always_comb begin
        w_s     = $signed({1'b0, w_mul_res}) - $signed({2'b00, r_r4[63:1]});
        w_s_abs = (w_s < 0) ? 65'(-w_s) : 65'(w_s);
        w_m     = w_mul_res[FRC_W-1:0];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == INDEX_W'(NUM_PARTICLES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_in_data.kind)
                        KIND_READ: n_state = w_new_a_ok ? ST_RD_F : ST_DONE;
                        KIND_PAIR: n_state = (w_new_a_ok && w_new_b_ok) ? ST_POS_A : ST_DONE;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_POS_A:   n_state = ST_POS_B;
            ST_POS_B:   n_state = ST_WRAP;
            ST_WRAP:    n_state = w_far ? ST_DONE : ST_SQ;
            ST_SQ:      n_state = ST_SQ_WAIT;
            ST_SQ_WAIT: begin
                if (w_mul_rsp.done) begin
                    n_state = (r_lane == 2'd2) ? ST_CMP : ST_SQ;
                end
            end
            ST_CMP: begin
                if (!w_in_cut || w_rd_zero) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_PWR;
                end
            end
            ST_PWR:      n_state = ST_PWR_WAIT;
            ST_PWR_WAIT: begin
                if (w_mul_rsp.done) begin
                    n_state = (r_step == 2'd3) ? ST_FRC : ST_PWR;
                end
            end
            ST_FRC:      n_state = ST_FRC_WAIT;
            ST_FRC_WAIT: begin
                if (w_mul_rsp.done) begin
                    n_state = (r_lane == 2'd2) ? ST_ACC_A_RD : ST_FRC;
                end
            end
            ST_ACC_A_RD: n_state = ST_ACC_A_WR;
            ST_ACC_A_WR: n_state = ST_ACC_B_RD;
            ST_ACC_B_RD: n_state = ST_ACC_B_WR;
            ST_ACC_B_WR: n_state = ST_DONE;
            ST_RD_F:     n_state = ST_RD_W;
            ST_RD_W:     n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs: handshake, store ports and unit requests.
    always_comb begin
        o_in_ready     = (r_state == ST_IDLE);
        w_pos_raddr    = (r_state == ST_POS_B) ? r_item.second_index : r_item.first_index;
        w_frc_raddr    = (r_state == ST_ACC_B_RD) ? r_item.second_index : r_item.first_index;
        w_frc_we       = 1'b0;
        w_frc_waddr    = r_item.first_index;
        w_frc_wdata    = '0;
        w_acc_sat      = 1'b0;
        w_mul_req.start = 1'b0;
        w_mul_req.mode  = MM_SQ;
        w_mul_a        = '0;
        w_mul_b        = '0;
        w_div_start    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                w_frc_we    = 1'b1;
                w_frc_waddr = r_clr_cnt;
            end
            ST_IDLE: begin
                // A load clears that particle's force as its position is written.
                w_frc_we    = w_in_acc && (i_in_data.kind == KIND_LOAD) && w_new_a_ok;
                w_frc_waddr = i_in_data.first_index;
            end
            ST_SQ: begin
                w_mul_req.start = 1'b1;
                w_mul_req.mode  = MM_SQ;
                w_mul_a         = 64'(r_dmag[r_lane]);
                w_mul_b         = 64'(r_dmag[r_lane]);
            end
            ST_CMP: begin
                w_div_start = w_in_cut && !w_rd_zero;
            end
            ST_PWR: begin
                w_mul_req.start = 1'b1;
                w_mul_req.mode  = MM_Q32;
                case (r_step)
                    2'd0: begin
                        w_mul_a = 64'(r_rr);
                        w_mul_b = 64'(r_rr);
                    end
                    2'd1: begin
                        w_mul_a = r_r2;
                        w_mul_b = r_r2;
                    end
                    2'd2: begin
                        w_mul_a = r_r2;
                        w_mul_b = r_r4;
                    end
                    default: begin
                        w_mul_a = r_r6;
                        w_mul_b = 64'(r_rr);
                    end
                endcase
            end
            ST_FRC: begin
                w_mul_req.start = 1'b1;
                w_mul_req.mode  = MM_FRC;
                w_mul_a         = 64'(r_dmag[r_lane]);
                w_mul_b         = 64'(r_smag);
            end
            ST_ACC_A_WR: begin
                w_frc_we    = 1'b1;
                w_frc_waddr = r_item.first_index;
                for (int k = 0; k < 3; k++) begin
                    logic [FRC_W:0] sa;
                    sa = sat_add(r_frc_q[(2-k)*FRC_W +: FRC_W], r_f[k]);
                    w_frc_wdata[(2-k)*FRC_W +: FRC_W] = sa[FRC_W-1:0];
                    w_acc_sat = w_acc_sat | sa[FRC_W];
                end
            end
            ST_ACC_B_WR: begin
                w_frc_we    = 1'b1;
                w_frc_waddr = r_item.second_index;
                for (int k = 0; k < 3; k++) begin
                    logic [FRC_W:0] sb;
                    sb = sat_add(r_frc_q[(2-k)*FRC_W +: FRC_W], -r_f[k]);
                    w_frc_wdata[(2-k)*FRC_W +: FRC_W] = sb[FRC_W-1:0];
                    w_acc_sat = w_acc_sat | sb[FRC_W];
                end
            end
            default: begin
                w_frc_we = 1'b0;
            end
        endcase
    end

    // Position store: written by load requests, read data registered.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in_data.kind == KIND_LOAD) && w_new_a_ok) begin
            r_pos_mem[i_in_data.first_index] <=
                {i_in_data.pos_x, i_in_data.pos_y, i_in_data.pos_z};
        end
        r_pos_q <= r_pos_mem[w_pos_raddr];
    end

    // Force store: clearing pass, load clears and the read-modify-write of a pair.
    always_ff @(posedge i_clk) begin
        if (w_frc_we) begin
            r_frc_mem[w_frc_waddr] <= w_frc_wdata;
        end
        r_frc_q <= r_frc_mem[w_frc_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_ovalid    <= 1'b0;
            r_half_box  <= '0;
            r_cutoff_sq <= CUTOFF_SQ_RST;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + INDEX_W'(1);
            end
            if ((r_state == ST_DONE) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_HALF_BOX:  r_half_box  <= i_cfg_data[CFG_W-1:0];
                    CFG_CUTOFF_SQ: r_cutoff_sq <= i_cfg_data[CFG_W-1:0];
                    default:       r_half_box  <= r_half_box;
                endcase
            end
        end
    end

    // Datapath registers of the request in work.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_item <= i_in_data;
                    r_res  <= '0;
                    r_sat  <= 1'b0;
                end
            end
            ST_POS_B: begin
                r_pa <= r_pos_q;
            end
            ST_WRAP: begin
                for (int k = 0; k < 3; k++) begin
                    r_dneg[k] <= (w_d[k] < 0);
                    r_dmag[k] <= (w_d[k] < 0) ? DMAG_W'(-w_d[k]) : DMAG_W'(w_d[k]);
                end
                r_sum  <= '0;
                r_lane <= 2'd0;
            end
            ST_SQ_WAIT: begin
                if (w_mul_rsp.done) begin
                    r_sum  <= r_sum + SUM_W'(w_mul_res[47:0]);
                    r_lane <= r_lane + 2'd1;
                end
            end
            ST_CMP: begin
                // Zero separation inside the cutoff is flagged and skipped.
                if (w_in_cut && w_rd_zero) begin
                    r_res.fault <= FAULT_ZERO;
                end
                r_step <= 2'd0;
            end
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    r_rr <= w_div_quot;
                end
            end
            ST_PWR_WAIT: begin
                if (w_mul_rsp.done) begin
                    r_sat  <= r_sat | w_mul_rsp.sat;
                    r_step <= r_step + 2'd1;
                    r_lane <= 2'd0;
                    case (r_step)
                        2'd0: r_r2 <= w_mul_res;
                        2'd1: r_r4 <= w_mul_res;
                        2'd2: r_r6 <= w_mul_res;
                        default: begin
                            r_sneg <= (w_s < 0);
                            r_smag <= w_s_abs[SMAG_W-1:0];
                        end
                    endcase
                end
            end
            ST_FRC_WAIT: begin
                if (w_mul_rsp.done) begin
                    r_sat <= r_sat | w_mul_rsp.sat;
                    r_f[r_lane] <= (r_dneg[r_lane] != r_sneg) ? -$signed(w_m)
                                                              : $signed(w_m);
                    r_lane <= r_lane + 2'd1;
                end
            end
            ST_ACC_A_WR: begin
                r_sat <= r_sat | w_acc_sat;
            end
            ST_ACC_B_WR: begin
                r_res.force_x       <= r_f[0];
                r_res.force_y       <= r_f[1];
                r_res.force_z       <= r_f[2];
                r_res.within_cutoff <= 1'b1;
                r_res.fault         <= (r_sat || w_acc_sat) ? FAULT_SAT : FAULT_NONE;
            end
            ST_RD_W: begin
                r_res.force_x <= r_frc_q[2*FRC_W +: FRC_W];
                r_res.force_y <= r_frc_q[FRC_W +: FRC_W];
                r_res.force_z <= r_frc_q[0 +: FRC_W];
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_out <= r_res;
                end
            end
            default: begin
                r_lane <= r_lane;
            end
        endcase
    end

endmodule

// File: rtl/pfa_mul.sv
// Shared multiply unit: 64 x 64 product from four 32 x 32 partials, then shift and clamp.
`timescale 1ns / 1ps
module pfa_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfa_pkg::t_mul_req i_req,
    input  logic [63:0]       i_a,
    input  logic [63:0]       i_b,
    output pfa_pkg::t_mul_rsp o_rsp,
    output logic [63:0]       o_result
);
    import pfa_pkg::*;

    logic         r_busy;
    logic [2:0]   r_step;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    t_mul_mode    r_mode;
    logic [63:0]  r_prod;
    logic         r_pvld;
    logic [1:0]   r_pshift;
    logic [127:0] r_acc;
    logic         r_done;
    logic         r_sat;
    logic [63:0]  r_result;

    logic [31:0]  w_pa;
    logic [31:0]  w_pb;
    logic [127:0] w_addend;
    logic [127:0] w_shifted;
    logic [63:0]  w_cap;
    logic         w_sat;

    always_comb begin
        w_pa = r_step[1] ? r_a[63:32] : r_a[31:0];
        w_pb = r_step[0] ? r_b[63:32] : r_b[31:0];
        case (r_pshift)
            2'd0:    w_addend = {64'b0, r_prod};
            2'd1:    w_addend = {32'b0, r_prod, 32'b0};
            default: w_addend = {r_prod, 64'b0};
        endcase
        case (r_mode)
            MM_Q32: begin
                w_shifted = r_acc >> 32;
                w_cap     = CAP_Q32;
            end
            MM_FRC: begin
                w_shifted = r_acc >> 24;
                w_cap     = CAP_FRC;
            end
            default: begin
                w_shifted = r_acc;
                w_cap     = CAP_SQ;
            end
        endcase
        w_sat = (w_shifted[127:64] != 64'b0) || (w_shifted[63:0] > w_cap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pvld <= 1'b0;
            r_step <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
                r_pvld <= 1'b0;
            end else if (r_busy) begin
                r_pvld <= (r_step < 3'd4);
                r_step <= r_step + 3'd1;
                if (r_step == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_mode <= i_req.mode;
            r_acc  <= 128'b0;
        end else if (r_busy) begin
            r_prod   <= w_pa * w_pb;
            r_pshift <= 2'(r_step[1]) + 2'(r_step[0]);
            if (r_pvld) begin
                r_acc <= r_acc + w_addend;
            end
            if (r_step == 3'd5) begin
                r_sat    <= w_sat;
                r_result <= w_sat ? w_cap : w_shifted[63:0];
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_result   = r_result;

endmodule

// File: rtl/pfa_div.sv
// Reciprocal unit: restoring division of 2^48 by the squared distance, one bit a cycle.
`timescale 1ns / 1ps
module pfa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pfa_pkg::CFG_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [pfa_pkg::RR_W-1:0]   o_quot
);
    import pfa_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CFG_W-1:0]     r_div;
    logic [CFG_W:0]       r_rem;
    logic [RR_W-1:0]      r_quot;

    logic [CFG_W:0]       w_trial;
    logic                 w_qbit;

    always_comb begin
        // The dividend is a single one followed by zeros.
        w_trial = {r_rem[CFG_W-1:0], (r_cnt == '0)};
        w_qbit  = (w_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rem  <= w_qbit ? (w_trial - {1'b0, r_div}) : w_trial;
            r_quot <= {r_quot[RR_W-2:0], w_qbit};
            r_cnt  <= r_cnt + DIV_CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: sim/tb.sv
// Self-checking testbench of the pair force accumulator core.
`timescale 1ns / 1ps
module tb;
    import pfa_pkg::*;

    localparam int  LIMIT_CYCLES = 1_000_000;
    localparam int  HOT_SET      = 32;
    localparam longint FMAX      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint FMIN      = -FMAX - 1;
    localparam longint FAR_LIM   = 64'sd16777216;
    localparam logic [63:0] CAP_INTER = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = CFG_HALF_BOX;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pair_force_accumulator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the block's state.
    logic signed [POS_W-1:0] pos_shadow [NUM_PARTICLES][3];
    logic signed [FRC_W-1:0] force_shadow [NUM_PARTICLES][3];
    bit                      pos_written [NUM_PARTICLES];
    int                      loaded_ids [$];
    logic [CFG_W-1:0]        half_box_cfg = '0;
    logic [CFG_W-1:0]        cutoff_sq_cfg = CUTOFF_SQ_RST;

    t_out expected_forces [$];
    int   mismatches = 0;
    int   cycles = 0;
    bit   no_idle = 1'b0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("** pair_force_accumulator_core: FAILED **");
            $finish;
        end
    end

    // floor(a*b / 2^sh), clamped at cap.
    function automatic logic [63:0] scaled_mul(input logic [63:0] a, input logic [63:0] b,
                                               input int sh, input logic [63:0] cap,
                                               inout bit sat);
        logic [127:0] p;
        p = ({64'b0, a} * {64'b0, b}) >> sh;
        if (p > {64'b0, cap}) begin
            sat = 1'b1;
            return cap;
        end
        return p[63:0];
    endfunction

    function automatic logic signed [FRC_W-1:0] acc_force(input logic signed [FRC_W-1:0] a,
                                                          input longint b, inout bit sat);
        longint s;
        s = longint'(a) + b;
        if (s > FMAX) begin
            sat = 1'b1;
            s = FMAX;
        end else if (s < FMIN) begin
            sat = 1'b1;
            s = FMIN;
        end
        return s[FRC_W-1:0];
    endfunction

    // Expected result of one request; updates the shadow stores.
    function automatic t_out predict_forces(input t_in r);
        t_out   o;
        int     a, b, k;
        longint d [3];
        longint f [3];
        longint h, v, s;
        bit     far, sat, dneg, sneg;
        logic [63:0] sum, rd, rr, r2, r4, r6, r7, smag, dmag, m;
        logic signed [POS_W-1:0] p [3];
        o = '0;
        a = int'(r.first_index);
        b = int'(r.second_index);
        f = '{0, 0, 0};
        far = 0;
        sat = 0;
        p = '{r.pos_x, r.pos_y, r.pos_z};
        if (r.kind == KIND_LOAD && a < NUM_PARTICLES) begin
            for (k = 0; k < 3; k++) begin
                pos_shadow[a][k] = p[k];
                force_shadow[a][k] = '0;
            end
            if (!pos_written[a]) loaded_ids = {loaded_ids, a};
            pos_written[a] = 1'b1;
        end else if (r.kind == KIND_READ && a < NUM_PARTICLES) begin
            for (k = 0; k < 3; k++) f[k] = longint'(force_shadow[a][k]);
        end else if (r.kind == KIND_PAIR && a < NUM_PARTICLES && b < NUM_PARTICLES) begin
            h = longint'(half_box_cfg);
            for (k = 0; k < 3; k++) begin
                v = longint'(pos_shadow[a][k]) - longint'(pos_shadow[b][k]);
                if (v < -h) v = v + 2 * h;
                if (v > h) v = v - 2 * h;
                d[k] = v;
                if (v >= FAR_LIM || v <= -FAR_LIM) far = 1;
            end
            if (!far) begin
                sum = '0;
                for (k = 0; k < 3; k++) sum = sum + 64'(d[k] * d[k]);
                rd = sum >> 16;
                if (rd < {33'b0, cutoff_sq_cfg}) begin
                    if (rd == 0) begin
                        o.fault = FAULT_ZERO;
                    end else begin
                        rr = (64'd1 << 48) / rd;
                        r2 = scaled_mul(rr, rr, 32, CAP_INTER, sat);
                        r4 = scaled_mul(r2, r2, 32, CAP_INTER, sat);
                        r6 = scaled_mul(r2, r4, 32, CAP_INTER, sat);
                        r7 = scaled_mul(r6, rr, 32, CAP_INTER, sat);
                        s = longint'(r7) - longint'(r4 >> 1);
                        sneg = s < 0;
                        smag = sneg ? 64'(-s) : 64'(s);
                        for (k = 0; k < 3; k++) begin
                            dneg = d[k] < 0;
                            dmag = dneg ? 64'(-d[k]) : 64'(d[k]);
                            m = scaled_mul(dmag, smag, 24, 64'(FMAX), sat);
                            f[k] = (dneg != sneg) ? -longint'(m) : longint'(m);
                            force_shadow[a][k] = acc_force(force_shadow[a][k], f[k], sat);
                            force_shadow[b][k] = acc_force(force_shadow[b][k], -f[k], sat);
                        end
                        o.within_cutoff = 1'b1;
                        o.fault = sat ? FAULT_SAT : FAULT_NONE;
                    end
                end
            end
        end
        o.force_x = f[0][FRC_W-1:0];
        o.force_y = f[1][FRC_W-1:0];
        o.force_z = f[2][FRC_W-1:0];
        return o;
    endfunction

    // Sends one request; valid stays high when the next one follows at once.
    task automatic send_request(input t_in r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge i_clk); while (!in_ready);
        expected_forces = {expected_forces, predict_forces(r)};
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_forces.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] half_box,
                                input logic [CFG_W-1:0] cutoff_sq);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HALF_BOX;
        cfg_data  <= {1'b0, half_box};
        do @(posedge i_clk); while (!cfg_ready);
        half_box_cfg = half_box;
        cfg_index <= CFG_CUTOFF_SQ;
        cfg_data  <= {1'b1, cutoff_sq};
        do @(posedge i_clk); while (!cfg_ready);
        cutoff_sq_cfg = cutoff_sq;
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in make_request(input logic [1:0] kind, input int i, input int j,
                                         input int x, input int y, input int z);
        t_in r;
        r.kind = kind;
        r.first_index = i[INDEX_W-1:0];
        r.second_index = j[INDEX_W-1:0];
        r.pos_x = x;
        r.pos_y = y;
        r.pos_z = z;
        return r;
    endfunction

    // Receiver: a fresh stall is drawn for every result.
    initial begin
        int n;
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 15);
            if (n > 0) begin
                out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    task automatic report_field(input string name, input logic [63:0] e, input logic [63:0] a);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", name, e, a);
    endtask

    // Each returned result is held against the oldest expectation.
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_forces.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", out_data);
            end else begin
                e = expected_forces.pop_front();
                if (out_data.force_x !== e.force_x)
                    report_field("force_x", 64'(e.force_x), 64'(out_data.force_x));
                if (out_data.force_y !== e.force_y)
                    report_field("force_y", 64'(e.force_y), 64'(out_data.force_y));
                if (out_data.force_z !== e.force_z)
                    report_field("force_z", 64'(e.force_z), 64'(out_data.force_z));
                if (out_data.within_cutoff !== e.within_cutoff)
                    report_field("within_cutoff", 64'(e.within_cutoff),
                                 64'(out_data.within_cutoff));
                if (out_data.fault !== e.fault)
                    report_field("fault", 64'(e.fault), 64'(out_data.fault));
            end
        end
    end

    // Extremes, every kind, zero distance, saturation and range limits.
    task automatic test_directed();
        send_request(make_request(KIND_LOAD, 0, 1023, 0, 0, 0));
        send_request(make_request(KIND_LOAD, 1, 0, 32'h0001_0000, 0, 0));
        send_request(make_request(KIND_PAIR, 0, 1, 0, 0, 0));
        send_request(make_request(KIND_LOAD, 2, 5, 0, 0, 0));
        send_request(make_request(KIND_PAIR, 0, 2, 0, 0, 0));
        send_request(make_request(KIND_PAIR, 1, 1, 0, 0, 0));
        send_request(make_request(KIND_LOAD, 3, 0, 256, 0, 0));
        send_request(make_request(KIND_PAIR, 3, 0, 0, 0, 0));
        send_request(make_request(KIND_PAIR, 3, 0, 0, 0, 0));
        send_request(make_request(KIND_READ, 3, 1023, -1, -1, -1));
        send_request(make_request(KIND_READ, 0, 0, 0, 0, 0));
        send_request(make_request(KIND_LOAD, 1023, 1023, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'hFFFF_FFFF));
        send_request(make_request(KIND_PAIR, 1023, 0, 0, 0, 0));
        send_request(make_request(KIND_LOAD, 4, 0, 0, 32'h0000_8000, 32'hFFFF_8000));
        send_request(make_request(KIND_PAIR, 4, 0, 0, 0, 0));
        send_request(make_request(KIND_PAIR, 0, 4, 0, 0, 0));
        send_request(make_request(KIND_READ, 1023, 0, 0, 0, 0));
        send_request(make_request(KIND_READ, 4, 0, 0, 0, 0));
        send_request(make_request(KIND_UNUSED, 1023, 1023, -1, -1, -1));
        send_request(make_request(KIND_LOAD, 0, 0, 0, 0, 0));
        send_request(make_request(KIND_READ, 0, 0, 0, 0, 0));
    endtask

    task automatic random_request();
        int roll, i, j, span;
        t_in r;
        roll = $urandom_range(0, 99);
        r = make_request(KIND_LOAD, $urandom_range(0, NUM_PARTICLES - 1),
                         $urandom_range(0, NUM_PARTICLES - 1), $urandom, $urandom, $urandom);
        if (roll < 50 && loaded_ids.size() >= 2) begin
            i = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
            j = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
            r.kind = KIND_PAIR;
            r.first_index = i[INDEX_W-1:0];
            r.second_index = j[INDEX_W-1:0];
        end else if (roll < 65) begin
            r.kind = KIND_READ;
            if ($urandom_range(0, 3) != 0 && loaded_ids.size() > 0) begin
                i = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
                r.first_index = i[INDEX_W-1:0];
            end
        end else if (roll < 70) begin
            r.kind = KIND_UNUSED;
        end else begin
            // Most positions sit in a small cluster so pairs fall inside the cutoff.
            if ($urandom_range(0, 3) != 0)
                r.first_index = INDEX_W'($urandom_range(0, HOT_SET - 1));
            if ($urandom_range(0, 6) != 0) begin
                span = 393216;
                r.pos_x = $urandom_range(0, 2 * span) - span;
                r.pos_y = $urandom_range(0, 2 * span) - span;
                r.pos_z = $urandom_range(0, 2 * span) - span;
            end
        end
        send_request(r);
    endtask

    task automatic test_random_phase(input logic [CFG_W-1:0] half_box,
                                     input logic [CFG_W-1:0] cutoff_sq, input int count);
        write_config(half_box, cutoff_sq);
        repeat (count) random_request();
    endtask

    initial begin
        foreach (force_shadow[i, k]) force_shadow[i][k] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_phase(31'h7FFF_FFFF, 31'h7FFF_FFFF, 200);
        test_random_phase(31'd196608, 31'd589824, 220);
        no_idle = 1'b1;
        test_random_phase(31'd655360, 31'd262144, 200);
        no_idle = 1'b0;
        test_random_phase(31'd0, 31'd0, 120);
        test_random_phase(CFG_W'($urandom_range(65536, 600000)), CFG_W'($urandom), 300);
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_forces.size() == 0)
            $display("** pair_force_accumulator_core: PASSED **");
        else
            $display("** pair_force_accumulator_core: FAILED **");
        $finish;
    end

endmodule
